// ===== rtl/core/alls_pkg.sv =====
// ----------------------------------------------------------------------------
// alls_pkg
// Shared types and codes of the array-based linked list store.
// ----------------------------------------------------------------------------
package alls_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_FIND = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD_LINK,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

// ===== rtl/core/alls_item_if.sv =====
// ----------------------------------------------------------------------------
// alls_item_if
// Command channel of the linked list store: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface alls_item_if;
  import alls_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] train_key;
  logic [TAG_W-1:0] tag_code;

  modport source (output valid, output cmd, output train_key, output tag_code,
                  input ready);
  modport sink   (input valid, input cmd, input train_key, input tag_code,
                  output ready);
endinterface

// ===== rtl/core/alls_result_if.sv =====
// ----------------------------------------------------------------------------
// alls_result_if
// Result channel of the linked list store: valid/ready plus status flags.
// ----------------------------------------------------------------------------
interface alls_result_if;
  logic valid;
  logic ready;
  logic ok;
  logic list_empty;

  modport source (output valid, output ok, output list_empty, input ready);
  modport sink   (input valid, input ok, input list_empty, output ready);
endinterface

// ===== rtl/core/array_linked_list_store.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_store
// Singly linked list of key/tag entries held in a table of SLOTS slots.
// ----------------------------------------------------------------------------
// One command is in work at a time and each gives exactly one result. Add
// scans the slot-used bits one slot per cycle for the lowest free slot, then
// links it after the tail, or finishes without a slot when the table is full.
// Delete and find walk the list through the entry memories at one slot per
// cycle (the registered read of the link memory sets this loop); an empty
// list or an unused command goes straight to the result. A finished result
// sits in an output register and the next command is taken in the cycle
// after the finished one has been loaded there. Slot 0 is the head; its link
// is kept in a register, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module array_linked_list_store
  import alls_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  alls_item_if.sink     item,
  alls_result_if.source result
);

  localparam int unsigned IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [IW-1:0] HEAD_SLOT = '0;

  // Entry memories
  entry_t        data_mem [SLOTS];
  logic [IW-1:0] link_mem [SLOTS];

  // Control and datapath registers
  state_t           state, state_next;
  logic [CMD_W-1:0] cmd_q, cmd_next;
  logic [KEY_W-1:0] key_q, key_next;
  logic [TAG_W-1:0] tag_q, tag_next;
  logic [IW-1:0]    scan_idx, scan_idx_next;
  logic [IW-1:0]    cur, cur_next;
  logic [IW-1:0]    prev, prev_next;
  logic [IW-1:0]    head, head_next;
  logic [IW-1:0]    tail, tail_next;
  logic [SLOTS-1:0] slot_used, slot_used_next;
  logic             op_ok, op_ok_next;
  logic             res_valid, res_valid_next;
  logic             res_ok, res_ok_next;
  logic             res_empty, res_empty_next;

  // Memory ports
  logic          dmem_we;
  logic [IW-1:0] dmem_addr;
  entry_t        dmem_wdata;
  logic          lmem_we;
  logic [IW-1:0] lmem_addr;
  logic [IW-1:0] lmem_wdata;
  logic [IW-1:0] rd_addr;
  entry_t        entry_q;
  logic [IW-1:0] link_q;

  // Follow the link as it comes out of memory; otherwise start at the head.
  assign rd_addr = (state == ST_WALK) ? link_q : head;

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      data_mem[dmem_addr] <= dmem_wdata;
    end
    entry_q <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lmem_we) begin
      link_mem[lmem_addr] <= lmem_wdata;
    end
    link_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= HEAD_SLOT;
      tail      <= HEAD_SLOT;
      slot_used <= SLOTS'(1);
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      slot_used <= slot_used_next;
      res_valid <= res_valid_next;
    end
    cmd_q     <= cmd_next;
    key_q     <= key_next;
    tag_q     <= tag_next;
    scan_idx  <= scan_idx_next;
    cur       <= cur_next;
    prev      <= prev_next;
    op_ok     <= op_ok_next;
    res_ok    <= res_ok_next;
    res_empty <= res_empty_next;
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd_q;
    key_next       = key_q;
    tag_next       = tag_q;
    scan_idx_next  = scan_idx;
    cur_next       = cur;
    prev_next      = prev;
    head_next      = head;
    tail_next      = tail;
    slot_used_next = slot_used;
    op_ok_next     = op_ok;
    res_ok_next    = res_ok;
    res_empty_next = res_empty;
    res_valid_next = res_valid && !result.ready;
    dmem_we        = 1'b0;
    dmem_addr      = scan_idx;
    dmem_wdata     = '{key: key_q, tag: tag_q};
    lmem_we        = 1'b0;
    lmem_addr      = scan_idx;
    lmem_wdata     = HEAD_SLOT;
    item.ready     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          cmd_next      = item.cmd;
          key_next      = item.train_key;
          tag_next      = item.tag_code;
          scan_idx_next = IW'(1);
          prev_next     = HEAD_SLOT;
          cur_next      = head;
          op_ok_next    = 1'b0;
          unique case (item.cmd)
            CMD_ADD:  state_next = ST_SCAN;
            CMD_DEL,
            CMD_FIND: state_next = (head == HEAD_SLOT) ? ST_FINISH : ST_WALK;
            default:  state_next = ST_FINISH;
          endcase
        end
      end

      ST_SCAN: begin
        if (!slot_used[scan_idx]) begin
          dmem_we                  = 1'b1;
          lmem_we                  = 1'b1;
          slot_used_next[scan_idx] = 1'b1;
          cur_next                 = scan_idx;
          state_next               = ST_ADD_LINK;
        end else if (scan_idx == LAST_SLOT) begin
          state_next = ST_FINISH;
        end else begin
          scan_idx_next = scan_idx + IW'(1);
        end
      end

      ST_ADD_LINK: begin
        // Append after the tail, or after the head when the list is empty.
        if (tail == HEAD_SLOT) begin
          head_next = cur;
        end else begin
          lmem_we    = 1'b1;
          lmem_addr  = tail;
          lmem_wdata = cur;
        end
        tail_next  = cur;
        op_ok_next = 1'b1;
        state_next = ST_FINISH;
      end

      ST_WALK: begin
        if (entry_q.key == key_q) begin
          op_ok_next = 1'b1;
          state_next = ST_FINISH;
          if (cmd_q == CMD_DEL) begin
            // Unlink the hit and free its slot.
            if (prev == HEAD_SLOT) begin
              head_next = link_q;
            end else begin
              lmem_we    = 1'b1;
              lmem_addr  = prev;
              lmem_wdata = link_q;
            end
            slot_used_next[cur] = 1'b0;
            if (tail == cur) begin
              tail_next = prev;
            end
          end
        end else if (link_q == HEAD_SLOT) begin
          state_next = ST_FINISH;
        end else begin
          prev_next = cur;
          cur_next  = link_q;
        end
      end

      ST_FINISH: begin
        // Hold until the output register is free.
        if (!res_valid || result.ready) begin
          res_valid_next = 1'b1;
          res_ok_next    = op_ok;
          res_empty_next = (head == HEAD_SLOT);
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign result.valid      = res_valid;
  assign result.ok         = res_ok;
  assign result.list_empty = res_empty;

  // The head slot is never released.
  a_head_used: assert property (@(posedge clk) disable iff (rst) slot_used[0])
    else $error("head slot marked free");

  // An empty list has its tail at the head, and the reverse.
  a_tail_head: assert property (@(posedge clk) disable iff (rst)
    (head == HEAD_SLOT) == (tail == HEAD_SLOT))
    else $error("head and tail disagree on an empty list");

  // A transfer in starts work; no second command is taken in the next cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("command taken while another is in work");

  // A tail that is not the head always points at a used slot.
  a_tail_used: assert property (@(posedge clk) disable iff (rst)
    slot_used[tail])
    else $error("tail points at a free slot");

endmodule

// ===== dv/tb_array_linked_list_store.sv =====
// ----------------------------------------------------------------------------
// tb_array_linked_list_store
// Self-checking bench for the array-based linked list store.
// ----------------------------------------------------------------------------
// A shadow of the slot table (keys, tags, links, used bits, tail) computes the
// status of every accepted command. The bench starts with a short scripted
// sequence: empty list, first and last entry deletes, duplicate keys, a full
// table and a tail that moves back. Random commands follow, with keys drawn
// partly from those in the list. Both channels idle at random in the first
// two of three phases. In the last, the result side stalls for a long stretch.
// ----------------------------------------------------------------------------
module tb_array_linked_list_store;
  import alls_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned LINK_W       = $clog2(SLOTS);
  localparam int unsigned RANDOM_ITEMS = 615;
  localparam int unsigned PHASE_LEN    = 217;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 3 * SLOTS;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned N_ROWS       = 24;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic ok;
    logic empty;
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [4:0]       reps;
    logic             typed;
    logic             ok;
    logic             empty;
  } stim_row_t;

  // Rows with typed set carry their status; the rest take it from the shadow.
  // A row with reps > 1 repeats with the key counting up.
  stim_row_t script [N_ROWS] = '{
    '{CMD_FIND,   16'h0000, 8'h00, 5'd1,  1'b1, 1'b0, 1'b1},
    '{CMD_DEL,    16'h0000, 8'h00, 5'd1,  1'b1, 1'b0, 1'b1},
    '{CMD_UNUSED, 16'hffff, 8'hff, 5'd1,  1'b1, 1'b0, 1'b1},
    '{CMD_ADD,    16'h0000, 8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_ADD,    16'hffff, 8'hff, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_DEL,    16'h0000, 8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_DEL,    16'hffff, 8'h00, 5'd1,  1'b1, 1'b1, 1'b1},
    '{CMD_ADD,    16'h00a5, 8'h11, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_ADD,    16'h00a5, 8'h22, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_DEL,    16'h00a5, 8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_FIND,   16'h00a5, 8'h00, 5'd1,  1'b1, 1'b1, 1'b0},
    '{CMD_DEL,    16'h1234, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0},
    '{CMD_UNUSED, 16'h0000, 8'h00, 5'd1,  1'b1, 1'b0, 1'b0},
    '{CMD_ADD,    16'h0100, 8'h5a, 5'd14, 1'b1, 1'b1, 1'b0},
    '{CMD_ADD,    16'h5a5a, 8'ha5, 5'd1,  1'b1, 1'b0, 1'b0},
    '{CMD_FIND,   16'h010d, 8'h00, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_DEL,    16'h0100, 8'h00, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_ADD,    16'h7777, 8'h77, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_DEL,    16'h7777, 8'h00, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_ADD,    16'h8888, 8'h88, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_FIND,   16'h8888, 8'h00, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_FIND,   16'h00a5, 8'h00, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_DEL,    16'h00a5, 8'h00, 5'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_FIND,   16'h00a5, 8'h00, 5'd1,  1'b0, 1'b0, 1'b0}
  };

  logic clk;
  logic rst;

  alls_item_if   item_ch ();
  alls_result_if result_ch ();

  array_linked_list_store #(
    .SLOTS (SLOTS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Shadow of the slot table
  logic [KEY_W-1:0]  shadow_key  [SLOTS];
  logic [TAG_W-1:0]  shadow_tag  [SLOTS];
  logic [LINK_W-1:0] shadow_link [SLOTS];
  bit                shadow_used [SLOTS];
  int unsigned       shadow_tail;

  status_t     pending_status [$];
  int unsigned errors;
  int unsigned sent_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one command to the shadow table and return the status it gives.
  function automatic status_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                             input logic [KEY_W-1:0] k,
                                             input logic [TAG_W-1:0] t);
    status_t     s;
    int unsigned i;
    int unsigned free_slot;
    int unsigned prev;
    int unsigned cur;
    int unsigned hit;
    int unsigned steps;
    s.ok = 1'b0;
    if (c == CMD_ADD) begin
      free_slot = 0;
      for (i = SLOTS - 1; i >= 1; i--) begin
        if (!shadow_used[i]) free_slot = i;
      end
      if (free_slot != 0) begin
        shadow_key[free_slot]   = k;
        shadow_tag[free_slot]   = t;
        shadow_link[free_slot]  = '0;
        shadow_used[free_slot]  = 1'b1;
        shadow_link[shadow_tail] = LINK_W'(free_slot);
        shadow_tail = free_slot;
        s.ok = 1'b1;
      end
    end else if (c == CMD_DEL || c == CMD_FIND) begin
      prev  = 0;
      cur   = shadow_link[0];
      hit   = 0;
      steps = 0;
      while (cur != 0 && steps < SLOTS && hit == 0) begin
        if (shadow_key[cur] == k) begin
          hit = cur;
        end else begin
          prev = cur;
          cur  = shadow_link[cur];
          steps++;
        end
      end
      if (hit != 0) begin
        s.ok = 1'b1;
        if (c == CMD_DEL) begin
          // Unlink the first match; if it was the tail, the tail falls back to its predecessor.
          shadow_link[prev] = shadow_link[hit];
          shadow_link[hit]  = '0;
          shadow_used[hit]  = 1'b0;
          if (shadow_tail == hit) shadow_tail = prev;
        end
      end
    end
    s.empty = (shadow_link[0] == '0);
    return s;
  endfunction

  // Favor keys that are in the list so deletes and finds hit.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned s;
    s = $urandom_range(1, SLOTS - 1);
    unique case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom);
      1:       return KEY_W'($urandom_range(0, 7));
      default: return shadow_used[s] ? shadow_key[s] : KEY_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                          input logic [TAG_W-1:0] t, input logic typed,
                          input status_t want);
    status_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.cmd       <= c;
    item_ch.train_key <= k;
    item_ch.tag_code  <= t;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    got = apply_list_cmd(c, k, t);
    pending_status.push_back(typed ? want : got);
    sent_count++;
    if (sent_count == PHASE_LEN) begin
      send_idle_pct = 86;
      recv_idle_pct = 38;
    end else if (sent_count == 2 * PHASE_LEN) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Result side: check each transfer, then pick ready for the next edge.
  initial begin
    status_t     want;
    int unsigned recv_count;
    int unsigned hold_left;
    bit          hold_done;
    recv_count = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        recv_count++;
        if (pending_status.size() == 0) begin
          $display("%0t: result with nothing pending: ok=%0b list_empty=%0b",
                   $time, result_ch.ok, result_ch.list_empty);
          errors++;
        end else begin
          want = pending_status.pop_front();
          if (result_ch.ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0b, got %0b",
                     $time, want.ok, result_ch.ok);
            errors++;
          end
          if (result_ch.list_empty !== want.empty) begin
            $display("%0t: list_empty mismatch: expected %0b, got %0b",
                     $time, want.empty, result_ch.list_empty);
            errors++;
          end
        end
      end
      // Hold off once, in the last phase, so the store backs up.
      if (!hold_done && recv_count == 2 * PHASE_LEN + 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned      i;
    int unsigned      r;
    int unsigned      n;
    int unsigned      roll;
    int unsigned      add_share;
    logic [CMD_W-1:0] c;
    stim_row_t        row;
    status_t          want;
    rst               = 1'b1;
    item_ch.valid     = 1'b0;
    item_ch.cmd       = CMD_ADD;
    item_ch.train_key = '0;
    item_ch.tag_code  = '0;
    errors        = 0;
    sent_count    = 0;
    send_idle_pct = 38;
    recv_idle_pct = 86;
    for (i = 0; i < SLOTS; i++) begin
      shadow_key[i]  = '0;
      shadow_tag[i]  = '0;
      shadow_link[i] = '0;
      shadow_used[i] = 1'b0;
    end
    shadow_used[0] = 1'b1;
    shadow_tail    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) begin
      row = script[i];
      want.ok    = row.ok;
      want.empty = row.empty;
      for (r = 0; r < row.reps; r++) begin
        send_cmd(row.cmd, row.key + KEY_W'(r), row.tag, row.typed, want);
      end
    end

    // Alternate between filling and draining the table every 50 commands.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      add_share = ((n / 50) % 2 == 0) ? 70 : 30;
      roll = $urandom_range(0, 99);
      if (roll < 3) c = CMD_UNUSED;
      else if (roll < add_share) c = CMD_ADD;
      else if (roll < (add_share + 100) / 2) c = CMD_DEL;
      else c = CMD_FIND;
      send_cmd(c, pick_key(), TAG_W'($urandom_range(0, 255)), 1'b0, '0);
    end
    item_ch.valid <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== array_linked_list_store.f =====
rtl/core/alls_pkg.sv
rtl/core/alls_item_if.sv
rtl/core/alls_result_if.sv
rtl/core/array_linked_list_store.sv
dv/tb_array_linked_list_store.sv
